[hdl/fsc_pkg.sv]
package fsc_pkg;

	// frame layout
	localparam int HEADER_BYTES   = 12;
	localparam int POSITION_WIDTH = 16;

	typedef logic [POSITION_WIDTH-1:0] pos_t;

	localparam pos_t POS_MAX    = '1;
	localparam pos_t SEQ_FIRST  = pos_t'(4);
	localparam pos_t SEQ_LAST   = pos_t'(7);
	localparam pos_t HCRC_FIRST = pos_t'(8);
	localparam pos_t HCRC_LAST  = pos_t'(HEADER_BYTES - 1);
	localparam pos_t HEADER_LEN = pos_t'(HEADER_BYTES);

	// reflected CRC-32, IEEE
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

	// stream widths
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 200;

	// tuser codes on the input side
	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_SHORT = 2'd1,
		STATUS_CRC   = 2'd2
	} status_t;

	// one byte through the reflected CRC, bit at a time
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
		end
		return r;
	endfunction

endpackage

[hdl/frame_sink_checker_core.sv]
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: command; tdata: data_byte[7:0], timestamp[39:8]; tlast: last_byte
// m_axis    out  tdata: frame_count, byte_total, error_count, seq_gap_count,
//                first_time, last_time (32 each), frame_status[193:192],
//                frame_gap[194], zero fill to 200
//
// One beat per cycle in while s_axis_tready is high; the CRC byte update and
// the statistics update are combinational from the frame state registers to
// the result register. A frame byte beat with tlast gives a result beat, shown
// the next cycle when the output is free; clear beats and other byte beats give none.
// Reset (arst_n low) zeroes the statistics and restarts the frame.
// Results go through a two-entry output buffer; s_axis_tready drops only when
// both entries hold a result the sink has not taken.
module frame_sink_checker_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [fsc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // data_byte, timestamp
	input  logic                               s_axis_tlast,   // last_byte
	input  logic                               s_axis_tuser,   // command
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [fsc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // see table above
);
	import fsc_pkg::*;

	// frame state
	logic [31:0] crc_q, crc_d;
	pos_t        pos_q, pos_d;
	logic [31:0] hseq_q, hseq_d;
	logic [31:0] hcrc_q, hcrc_d;

	// statistics
	logic [31:0] frames_q, frames_d;
	logic [31:0] bytes_q, bytes_d;
	logic [31:0] errors_q, errors_d;
	logic [31:0] gaps_q, gaps_d;
	logic [31:0] prev_q, prev_d;
	logic [31:0] tfirst_q, tfirst_d;
	logic [31:0] tlast_q, tlast_d;

	logic [7:0]  in_byte;
	logic [31:0] in_time;
	logic        in_beat;
	logic        out_beat;
	logic        push;
	status_t     status;
	logic        gap;
	logic [OUT_TDATA_W-1:0] result;

	// output buffer: head register plus skid entry
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   skid_valid_q;
	logic [OUT_TDATA_W-1:0] skid_data_q;

	assign in_byte  = s_axis_tdata[7:0];
	assign in_time  = s_axis_tdata[39:8];
	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = out_valid_q && m_axis_tready;

	assign s_axis_tready = !skid_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		crc_d    = crc_q;
		pos_d    = pos_q;
		hseq_d   = hseq_q;
		hcrc_d   = hcrc_q;
		frames_d = frames_q;
		bytes_d  = bytes_q;
		errors_d = errors_q;
		gaps_d   = gaps_q;
		prev_d   = prev_q;
		tfirst_d = tfirst_q;
		tlast_d  = tlast_q;
		status   = STATUS_OK;
		gap      = 1'b0;
		push     = 1'b0;

		if (in_beat) begin
			if (s_axis_tuser == CMD_CLEAR) begin
				// clear also drops a partial frame
				frames_d = '0;
				bytes_d  = '0;
				errors_d = '0;
				gaps_d   = '0;
				prev_d   = '0;
				tfirst_d = '0;
				tlast_d  = '0;
				crc_d    = CRC_ONES;
				pos_d    = '0;
				hseq_d   = '0;
				hcrc_d   = '0;
			end else begin
				// bytes 0..3 are opcode and pad, not inspected
				if (pos_q inside {[SEQ_FIRST:SEQ_LAST]}) begin
					hseq_d[8*pos_q[1:0] +: 8] = in_byte;
				end else if (pos_q inside {[HCRC_FIRST:HCRC_LAST]}) begin
					hcrc_d[8*pos_q[1:0] +: 8] = in_byte;
				end else if (pos_q >= HEADER_LEN) begin
					crc_d = crc_byte(crc_q, in_byte);
				end
				if (pos_q != POS_MAX) begin
					pos_d = pos_q + 1'b1;
				end

				if (s_axis_tlast) begin
					push = 1'b1;
					if (pos_d < HEADER_LEN) begin
						errors_d = errors_q + 32'd1;
						status   = STATUS_SHORT;
					end else begin
						if (frames_q == '0) begin
							tfirst_d = in_time;
						end else if (hseq_d != prev_q + 32'd1) begin
							gaps_d = gaps_q + 32'd1;
							gap    = 1'b1;
						end
						tlast_d = in_time;
						prev_d  = hseq_d;
						if ((crc_d ^ CRC_ONES) != hcrc_d) begin
							errors_d = errors_q + 32'd1;
							status   = STATUS_CRC;
						end
						frames_d = frames_q + 32'd1;
						bytes_d  = bytes_q + 32'(pos_d);
					end
					crc_d  = CRC_ONES;
					pos_d  = '0;
					hseq_d = '0;
					hcrc_d = '0;
				end
			end
		end
	end

	assign result = {5'd0, gap, 2'(status), tlast_d, tfirst_d, gaps_d, errors_d,
		bytes_d, frames_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= CRC_ONES;
			pos_q    <= '0;
			hseq_q   <= '0;
			hcrc_q   <= '0;
			frames_q <= '0;
			bytes_q  <= '0;
			errors_q <= '0;
			gaps_q   <= '0;
			prev_q   <= '0;
			tfirst_q <= '0;
			tlast_q  <= '0;
		end else begin
			crc_q    <= crc_d;
			pos_q    <= pos_d;
			hseq_q   <= hseq_d;
			hcrc_q   <= hcrc_d;
			frames_q <= frames_d;
			bytes_q  <= bytes_d;
			errors_q <= errors_d;
			gaps_q   <= gaps_d;
			prev_q   <= prev_d;
			tfirst_q <= tfirst_d;
			tlast_q  <= tlast_d;
		end
	end

	// output buffer valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_beat) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output buffer payload, no reset
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_beat) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				if (push) begin
					skid_data_q <= result;
				end
			end else if (push) begin
				out_data_q <= result;
			end
		end else if (push) begin
			skid_data_q <= result;
		end
	end

endmodule

[hdl/fsc_checker.sv]
module fsc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic [fsc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input logic                               s_axis_tlast,
	input logic                               s_axis_tuser,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [fsc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import fsc_pkg::*;

	logic in_beat;
	assign in_beat = s_axis_tvalid && s_axis_tready;

	// a frame end always leaves a result ready next cycle
	a_frame_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && s_axis_tuser == CMD_BYTE && s_axis_tlast |=> m_axis_tvalid)
		else $error("frame end gave no result");

	// a clear with nothing pending produces nothing
	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && s_axis_tuser == CMD_CLEAR && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("clear produced a result");

	// short frames never count as sequence gaps
	a_short_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[193:192] == STATUS_SHORT |-> !m_axis_tdata[194])
		else $error("short frame flagged as gap");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

endmodule

bind frame_sink_checker_core fsc_checker u_fsc_checker (.*);
